/* design/tpf_pkg.sv */
// ----------------------------------------------------------------------------
// Thrust-to-PWM framer package
// Shared sizes, command codes, queue entry type and interpolation constants.
// ----------------------------------------------------------------------------
package tpf_pkg;

    // Table geometry and frame length.
    localparam int TABLE_ENTRIES  = 201;
    localparam int THRUSTER_COUNT = 8;
    localparam int TABLE_COUNT    = 3;
    localparam int IDX_W          = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W         = (THRUSTER_COUNT > 1) ? $clog2(THRUSTER_COUNT) : 1;

    // Payload widths.
    localparam int PWM_W  = 16;
    localparam int VOLT_W = 15;

    // Supply voltage limits and the reset voltage, in millivolts.
    localparam int V_LOW_MV   = 14000;
    localparam int V_MID_MV   = 16000;
    localparam int V_HIGH_MV  = 18000;
    localparam int V_RESET_MV = 15500;

    // Force index: round(force * 100) + 100 in Q2.14.
    localparam int FORCE_SCALE  = 100;
    localparam int FORCE_HALF   = 8192;
    localparam int FORCE_FRAC   = 14;
    localparam int INDEX_CENTER = 100;

    // Interpolation divides by the 2000 mV span as a shift by 4 and a
    // divide by 125. The divide by 125 runs on a biased, non-negative value
    // through a reciprocal multiply that is exact below 2^24.
    localparam int DIV_PRESHIFT = 4;
    localparam int DIV_CONST    = 125;
    localparam int DIV_OFFSET   = 65536;
    localparam int DIV_BIAS     = DIV_CONST * DIV_OFFSET;
    localparam int INTERP_SHIFT = 31;
    localparam int RECIP_W      = 25;
    localparam int BIASED_W     = 24;
    localparam int QUOT_W       = 18;
    localparam logic [RECIP_W-1:0] INTERP_RECIP =
        RECIP_W'(((64'd1 << INTERP_SHIFT) + 64'(DIV_CONST - 1)) / 64'(DIV_CONST));

    // Command queue depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input function codes.
    localparam logic [1:0] FUNC_TABLE_WRITE = 2'd0;
    localparam logic [1:0] FUNC_VOLTAGE     = 2'd1;
    localparam logic [1:0] FUNC_FORCE       = 2'd2;

    // One command passed from the front end to the interpolation back end.
    typedef struct packed {
        logic              is_write;
        logic [1:0]        sel;
        logic [IDX_W-1:0]  index;
        logic [PWM_W-1:0]  value;
        logic [VOLT_W-1:0] volt;
    } tpf_cmd_t;

endpackage

/* design/tpf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 201
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* design/tpf_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats, keeps the supply voltage and turns force commands and
// valid table writes into queue commands.
// ----------------------------------------------------------------------------
module tpf_front import tpf_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [1:0]              table_select,
    input  logic [7:0]              table_index,
    input  logic [15:0]             table_value,
    input  logic [15:0]             voltage_mv,
    input  logic signed [15:0]      force_q14,
    input  logic                    q_full,
    output logic                    q_push,
    output tpf_cmd_t                q_cmd
);

    localparam logic signed [11:0] IDX_MAX_S = 12'(TABLE_ENTRIES - 1);

    logic [VOLT_W-1:0]  volt_reg;
    logic [VOLT_W-1:0]  volt_next;
    logic               accept;
    logic               write_ok;
    logic signed [23:0] force_ext;
    logic signed [23:0] force_scaled;
    logic signed [11:0] idx_raw;
    logic [IDX_W-1:0]   idx_sat;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // A table write is kept only for an existing table and entry.
    assign write_ok = (table_select < 2'(TABLE_COUNT))
                   && (11'(table_index) < 11'(TABLE_ENTRIES));

    // Round the Q2.14 force to hundredths and center it on the table.
    always_comb
    begin
        force_ext    = 24'(force_q14);
        force_scaled = force_ext * 24'sd100 + 24'(FORCE_HALF);
        idx_raw      = 12'(force_scaled >>> FORCE_FRAC) + 12'(INDEX_CENTER);
        if (idx_raw < 12'sd0)
        begin
            idx_sat = '0;
        end
        else if (idx_raw > IDX_MAX_S)
        begin
            idx_sat = IDX_W'(TABLE_ENTRIES - 1);
        end
        else
        begin
            idx_sat = IDX_W'(unsigned'(idx_raw));
        end
    end

    // Clamp a new supply voltage to the table range.
    always_comb
    begin
        volt_next = volt_reg;
        if (accept && func == FUNC_VOLTAGE)
        begin
            if (voltage_mv < 16'(V_LOW_MV))
            begin
                volt_next = VOLT_W'(V_LOW_MV);
            end
            else if (voltage_mv > 16'(V_HIGH_MV))
            begin
                volt_next = VOLT_W'(V_HIGH_MV);
            end
            else
            begin
                volt_next = VOLT_W'(voltage_mv);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg <= VOLT_W'(V_RESET_MV);
        end
        else
        begin
            volt_reg <= volt_next;
        end
    end

    // Build the queue command; a force carries the voltage in effect now.
    always_comb
    begin
        q_push         = 1'b0;
        q_cmd.is_write = (func == FUNC_TABLE_WRITE);
        q_cmd.sel      = table_select;
        q_cmd.index    = idx_sat;
        q_cmd.value    = table_value;
        q_cmd.volt     = volt_reg;
        case (func)
            FUNC_TABLE_WRITE:
            begin
                q_cmd.index = IDX_W'(table_index);
                q_push      = accept && write_ok;
            end
            FUNC_FORCE:
            begin
                q_push = accept;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

/* design/tpf_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// A short FIFO that lets the front end and the back end stall separately.
// ----------------------------------------------------------------------------
module tpf_queue import tpf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tpf_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output tpf_cmd_t pop_cmd,
    output logic     empty
);

    tpf_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/tpf_back.sv */
// ----------------------------------------------------------------------------
// Interpolation back end
// Executes queued table writes and runs force commands through a four-stage
// pipeline: table read, bracket select, product, reciprocal divide.
// ----------------------------------------------------------------------------
module tpf_back import tpf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  tpf_cmd_t         q_cmd,
    output logic             q_pop,
    output logic             item_valid,
    output logic [PWM_W-1:0] item_pwm,
    input  logic             item_take
);

    logic                    adv;
    logic                    rd_en;
    logic [PWM_W-1:0]        rd_data [TABLE_COUNT];

    logic                    s1_valid_reg;
    logic [VOLT_W-1:0]       s1_volt_reg;
    logic                    s2_valid_reg;
    logic [PWM_W-1:0]        s2_y1_reg;
    logic signed [16:0]      s2_dy_reg;
    logic [10:0]             s2_dv_reg;
    logic                    s3_valid_reg;
    logic [PWM_W-1:0]        s3_y1_reg;
    logic signed [28:0]      s3_prod_reg;
    logic                    s4_valid_reg;
    logic [PWM_W-1:0]        s4_y1_reg;
    logic [BIASED_W+RECIP_W-1:0] s4_prod_reg;

    logic                    upper;
    logic [PWM_W-1:0]        y1_sel;
    logic [PWM_W-1:0]        y2_sel;
    logic signed [16:0]      dy_next;
    logic [10:0]             dv_next;
    logic signed [28:0]      dy_ext;
    logic signed [28:0]      dv_ext;
    logic signed [24:0]      scaled;
    logic [BIASED_W-1:0]     biased;
    logic [QUOT_W-1:0]       quot;

    // The whole pipeline moves when its last stage is empty or handed off.
    assign adv   = !s4_valid_reg || item_take;
    assign q_pop = adv && !q_empty;
    assign rd_en = q_pop && !q_cmd.is_write;

    // One table RAM per supply voltage; a force reads all three.
    for (genvar g = 0; g < TABLE_COUNT; g++)
    begin : g_table
        tpf_ram #(
            .WIDTH(PWM_W),
            .DEPTH(TABLE_ENTRIES)
        ) u_ram (
            .clk     (clk),
            .wr_en   (q_pop && q_cmd.is_write && (q_cmd.sel == 2'(g))),
            .wr_addr (q_cmd.index),
            .wr_data (q_cmd.value),
            .rd_en   (rd_en),
            .rd_addr (q_cmd.index),
            .rd_data (rd_data[g])
        );
    end

    // Pick the table pair and the offset into the 2000 mV span.
    always_comb
    begin
        upper   = (s1_volt_reg > VOLT_W'(V_MID_MV));
        y1_sel  = upper ? rd_data[1] : rd_data[0];
        y2_sel  = upper ? rd_data[2] : rd_data[1];
        dy_next = signed'({1'b0, y2_sel}) - signed'({1'b0, y1_sel});
        dv_next = 11'(s1_volt_reg - (upper ? VOLT_W'(V_MID_MV) : VOLT_W'(V_LOW_MV)));
    end

    // Product and biased floor division by the span.
    always_comb
    begin
        dy_ext = 29'(s2_dy_reg);
        dv_ext = 29'(signed'({1'b0, s2_dv_reg}));
        scaled = 25'(s3_prod_reg >>> DIV_PRESHIFT);
        biased = BIASED_W'(scaled + 25'(DIV_BIAS));
        quot   = s4_prod_reg[INTERP_SHIFT +: QUOT_W];
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_volt_reg <= q_cmd.volt;
            s2_y1_reg   <= y1_sel;
            s2_dy_reg   <= dy_next;
            s2_dv_reg   <= dv_next;
            s3_y1_reg   <= s2_y1_reg;
            s3_prod_reg <= dy_ext * dv_ext;
            s4_y1_reg   <= s3_y1_reg;
            s4_prod_reg <= (BIASED_W+RECIP_W)'(biased) * (BIASED_W+RECIP_W)'(INTERP_RECIP);
        end
    end

    // The interpolated word always lies between the two table values.
    assign item_valid = s4_valid_reg;
    assign item_pwm   = PWM_W'({2'b00, s4_y1_reg} + quot - QUOT_W'(DIV_OFFSET));

endmodule

/* design/tpf_framer.sv */
// ----------------------------------------------------------------------------
// Frame serializer
// Sends each PWM word as low and high byte and closes every frame with the
// running XOR checksum.
// ----------------------------------------------------------------------------
module tpf_framer import tpf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [PWM_W-1:0] item_pwm,
    output logic             item_take,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       serial_byte,
    output logic [15:0]      pwm_value,
    output logic             frame_last
);

    typedef enum logic [1:0] {
        ST_EMPTY,
        ST_LOW,
        ST_HIGH,
        ST_CHECK
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [7:0]        csum_reg;
    logic [7:0]        csum_next;
    logic              end_reg;
    logic              end_next;
    logic [7:0]        serial_byte_reg;
    logic [7:0]        serial_byte_next;
    logic [15:0]       pwm_value_reg;
    logic [15:0]       pwm_value_next;
    logic              frame_last_reg;
    logic              frame_last_next;
    logic              beat_done;
    logic              can_load;

    assign beat_done = (state_reg != ST_EMPTY) && !out_stall;

    // A new word enters when nothing is shown or the last beat of an item leaves.
    always_comb
    begin
        case (state_reg)
            ST_EMPTY: can_load = 1'b1;
            ST_HIGH:  can_load = beat_done && !end_reg;
            ST_CHECK: can_load = beat_done;
            default:  can_load = 1'b0;
        endcase
    end

    assign item_take = can_load && item_valid;

    // Next beat, checksum and slot count.
    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        csum_next        = csum_reg;
        end_next         = end_reg;
        serial_byte_next = serial_byte_reg;
        pwm_value_next   = pwm_value_reg;
        frame_last_next  = frame_last_reg;
        if (item_take)
        begin
            state_next       = ST_LOW;
            serial_byte_next = item_pwm[7:0];
            pwm_value_next   = item_pwm;
            frame_last_next  = 1'b0;
            csum_next        = csum_reg ^ item_pwm[7:0] ^ item_pwm[15:8];
            end_next         = (slot_reg == SLOT_W'(THRUSTER_COUNT - 1));
            slot_next        = end_next ? '0 : slot_reg + 1'b1;
        end
        else if (beat_done)
        begin
            case (state_reg)
                ST_LOW:
                begin
                    state_next       = ST_HIGH;
                    serial_byte_next = pwm_value_reg[15:8];
                end
                ST_HIGH:
                begin
                    if (end_reg)
                    begin
                        state_next       = ST_CHECK;
                        serial_byte_next = csum_reg;
                        pwm_value_next   = '0;
                        frame_last_next  = 1'b1;
                        csum_next        = '0;
                        end_next         = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    state_next = ST_EMPTY;
                end
            endcase
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_EMPTY;
            slot_reg        <= '0;
            csum_reg        <= '0;
            end_reg         <= 1'b0;
            serial_byte_reg <= '0;
            pwm_value_reg   <= '0;
            frame_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            csum_reg        <= csum_next;
            end_reg         <= end_next;
            serial_byte_reg <= serial_byte_next;
            pwm_value_reg   <= pwm_value_next;
            frame_last_reg  <= frame_last_next;
        end
    end

    assign out_valid   = (state_reg != ST_EMPTY);
    assign serial_byte = serial_byte_reg;
    assign pwm_value   = pwm_value_reg;
    assign frame_last  = frame_last_reg;

endmodule

/* design/thrust_to_pwm_interpolating_framer.sv */
// ----------------------------------------------------------------------------
// Thrust-to-PWM interpolating framer
// Loads three PWM tables, tracks supply voltage and sends interpolated PWM
// words for each thruster as a byte stream with a closing checksum.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) takes one beat per cycle unless
// stalled: a table write, a voltage update or a force command. Table writes
// and force commands go through a four-entry command queue; voltage updates
// take effect at once for every later force. in_stall rises only while
// that queue is full. The output channel (out_valid, out_stall) sends two
// beats per force, the low and high PWM byte, and after every eighth force a
// checksum beat with frame_last set and pwm_value zero.
// A force accepted into an idle block passes through the queue, one table
// RAM read, then the select, multiply and reciprocal-divide stages before
// its first byte shows. The output serializer limits the flow: it takes the
// next force as the last high byte leaves, or after a checksum beat.
// While the receiver stalls, the shown beat holds, the pipeline and queue
// fill, and in_stall follows. Reset sets the voltage to 15500 mV and clears
// the frame slot count and checksum; table contents stay undefined until
// written.
// ----------------------------------------------------------------------------
module thrust_to_pwm_interpolating_framer import tpf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [1:0]         table_select,
    input  logic [7:0]         table_index,
    input  logic [15:0]        table_value,
    input  logic [15:0]        voltage_mv,
    input  logic signed [15:0] force_q14,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         serial_byte,
    output logic [15:0]        pwm_value,
    output logic               frame_last
);

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    tpf_cmd_t         push_cmd;
    tpf_cmd_t         pop_cmd;
    logic             item_valid;
    logic [PWM_W-1:0] item_pwm;
    logic             item_take;

    tpf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .table_select (table_select),
        .table_index  (table_index),
        .table_value  (table_value),
        .voltage_mv   (voltage_mv),
        .force_q14    (force_q14),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    tpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .item_valid (item_valid),
        .item_pwm   (item_pwm),
        .item_take  (item_take)
    );

    tpf_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_pwm    (item_pwm),
        .item_take   (item_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .serial_byte (serial_byte),
        .pwm_value   (pwm_value),
        .frame_last  (frame_last)
    );

`ifndef SYNTHESIS
    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    // The checksum beat carries no PWM word.
    a_check_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (pwm_value == 16'd0))
        else $error("checksum beat with nonzero pwm_value");

    // Two checksum beats never follow each other.
    a_single_check: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && frame_last) |=> !(out_valid && frame_last))
        else $error("checksum beat repeated");
`endif

endmodule

/* tb/thrust_to_pwm_interpolating_framer_tb.sv */
// ----------------------------------------------------------------------------
// Thrust-to-PWM interpolating framer testbench
// Drives table writes, voltage updates and force commands into the framer.
// A shadow copy of the tables, voltage and frame state predicts every output
// beat, and a checker compares each beat against the oldest prediction.
// Random stall bursts, a long receiver hold and a drained pause stress the
// handshakes on both sides.
// ----------------------------------------------------------------------------
module thrust_to_pwm_interpolating_framer_tb import tpf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Table select codes and the unused function code.
    localparam logic [1:0] SEL_14V     = 2'd0;
    localparam logic [1:0] SEL_16V     = 2'd1;
    localparam logic [1:0] SEL_18V     = 2'd2;
    localparam logic [1:0] SEL_BAD     = 2'd3;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int SPAN_MV        = V_MID_MV - V_LOW_MV;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int MAX_PRINTS     = 40;

    // One input beat.
    typedef struct {
        logic [1:0]         func;
        logic [1:0]         tsel;
        logic [7:0]         tidx;
        logic [15:0]        tval;
        logic [15:0]        mv;
        logic signed [15:0] thrust;
    } cmd_beat_t;

    // One predicted output beat.
    typedef struct {
        logic [7:0]  sbyte;
        logic [15:0] pwm;
        logic        last;
    } frame_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = '0;
    logic [1:0]         table_select = '0;
    logic [7:0]         table_index = '0;
    logic [15:0]        table_value = '0;
    logic [15:0]        voltage_mv = '0;
    logic signed [15:0] force_q14 = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         serial_byte;
    logic [15:0]        pwm_value;
    logic               frame_last;

    // Shadow state of the block.
    logic [15:0] pwm_shadow [TABLE_COUNT][TABLE_ENTRIES];
    bit          shadow_written [TABLE_COUNT][TABLE_ENTRIES];
    int          shadow_mv = V_RESET_MV;
    int          shadow_slot = 0;
    logic [7:0]  shadow_csum = '0;

    frame_beat_t frame_bytes_q[$];

    // Run controls and statistics.
    bit sender_idle_en = 1'b0;
    bit recv_idle_en   = 1'b0;
    int hold_left      = 0;
    int errors         = 0;
    int n_forces       = 0;
    int n_frames       = 0;
    int n_writes       = 0;
    int n_volts        = 0;
    int n_ignored      = 0;
    int n_checked      = 0;

    thrust_to_pwm_interpolating_framer u_top (.*);

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Append one predicted beat to the end of the scoreboard.
    task automatic queue_beat(input logic [7:0] sbyte, input logic [15:0] pwm,
                              input logic last);
        frame_beat_t b;
        b.sbyte = sbyte;
        b.pwm   = pwm;
        b.last  = last;
        frame_bytes_q.insert(frame_bytes_q.size(), b);
    endtask

    function automatic int floor_div(input int num, input int den);
        if (num >= 0)
        begin
            return num / den;
        end
        return -((-num + den - 1) / den);
    endfunction

    // Round a Q2.14 force half up to a table index and saturate it.
    function automatic int force_to_index(input logic signed [15:0] f);
        int num;
        int idx;
        num = int'(f) * FORCE_SCALE + FORCE_HALF;
        idx = (num >>> FORCE_FRAC) + INDEX_CENTER;
        if (idx < 0)
        begin
            idx = 0;
        end
        if (idx > TABLE_ENTRIES - 1)
        begin
            idx = TABLE_ENTRIES - 1;
        end
        return idx;
    endfunction

    // First table of the pair that the current voltage interpolates between.
    function automatic int lower_table();
        return (shadow_mv <= V_MID_MV) ? 0 : 1;
    endfunction

    // Interpolate between the two tables in millivolts, floor the quotient and clamp.
    function automatic int interp_pwm(input int idx);
        int lo_t;
        int y1;
        int y2;
        int v1;
        int q;
        lo_t = lower_table();
        y1 = int'(pwm_shadow[lo_t][idx]);
        y2 = int'(pwm_shadow[lo_t + 1][idx]);
        v1 = (lo_t == 0) ? V_LOW_MV : V_MID_MV;
        q = y1 + floor_div((y2 - y1) * (shadow_mv - v1), SPAN_MV);
        if (q < 0)
        begin
            q = 0;
        end
        if (q > 65535)
        begin
            q = 65535;
        end
        return q;
    endfunction

    // Update the shadow state for an accepted beat and queue its output.
    task automatic apply_to_model(input cmd_beat_t it);
        int idx;
        int mv;
        logic [15:0] pwm;
        case (it.func)
            FUNC_TABLE_WRITE:
            begin
                if (it.tsel != SEL_BAD && it.tidx < TABLE_ENTRIES)
                begin
                    pwm_shadow[it.tsel][it.tidx] = it.tval;
                    shadow_written[it.tsel][it.tidx] = 1'b1;
                    n_writes++;
                end
                else
                begin
                    n_ignored++;
                end
            end
            FUNC_VOLTAGE:
            begin
                mv = int'(it.mv);
                if (mv < V_LOW_MV)
                begin
                    mv = V_LOW_MV;
                end
                if (mv > V_HIGH_MV)
                begin
                    mv = V_HIGH_MV;
                end
                shadow_mv = mv;
                n_volts++;
            end
            FUNC_FORCE:
            begin
                idx = force_to_index(it.thrust);
                pwm = 16'(interp_pwm(idx));
                shadow_csum = shadow_csum ^ pwm[7:0] ^ pwm[15:8];
                queue_beat(pwm[7:0], pwm, 1'b0);
                queue_beat(pwm[15:8], pwm, 1'b0);
                n_forces++;
                shadow_slot++;
                if (shadow_slot >= THRUSTER_COUNT)
                begin
                    queue_beat(shadow_csum, 16'h0, 1'b1);
                    shadow_slot = 0;
                    shadow_csum = '0;
                    n_frames++;
                end
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endtask

    // Offer one beat, wait for acceptance, then update the shadow state.
    task automatic send_item(input cmd_beat_t it);
        int gap;
        @(negedge clk);
        if (sender_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= it.func;
        table_select <= it.tsel;
        table_index  <= it.tidx;
        table_value  <= it.tval;
        voltage_mv   <= it.mv;
        force_q14    <= it.thrust;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        apply_to_model(it);
    endtask

    // Beat with random content in every field; callers set what matters.
    function automatic cmd_beat_t random_beat(input logic [1:0] f);
        cmd_beat_t it;
        it.func   = f;
        it.tsel   = 2'($urandom);
        it.tidx   = 8'($urandom);
        it.tval   = 16'($urandom);
        it.mv     = 16'($urandom);
        it.thrust = 16'($urandom);
        return it;
    endfunction

    task automatic send_write(input logic [1:0] sel, input logic [7:0] idx,
                              input logic [15:0] val);
        cmd_beat_t it;
        it = random_beat(FUNC_TABLE_WRITE);
        it.tsel = sel;
        it.tidx = idx;
        it.tval = val;
        send_item(it);
    endtask

    task automatic send_voltage(input logic [15:0] mv);
        cmd_beat_t it;
        it = random_beat(FUNC_VOLTAGE);
        it.mv = mv;
        send_item(it);
    endtask

    // Load any table entry the force would read that is still unwritten,
    // then send the force itself.
    task automatic send_force(input logic signed [15:0] f);
        cmd_beat_t it;
        int idx;
        int lo_t;
        idx = force_to_index(f);
        lo_t = lower_table();
        for (int t = lo_t; t <= lo_t + 1; t++)
        begin
            if (!shadow_written[t][idx])
            begin
                send_write(2'(t), 8'(idx), 16'($urandom));
            end
        end
        it = random_beat(FUNC_FORCE);
        it.thrust = f;
        send_item(it);
    endtask

    function automatic logic signed [15:0] random_thrust();
        if ($urandom_range(0, 9) < 7)
        begin
            return 16'(int'($urandom_range(0, 32768)) - 16384);
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] random_voltage();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return 16'($urandom_range(V_LOW_MV, V_HIGH_MV));
        end
        if (r == 7)
        begin
            return 16'($urandom_range(V_MID_MV - 2, V_MID_MV + 2));
        end
        return 16'($urandom);
    endfunction

    // Mostly forces and voltages, with some writes, bad writes and no-ops.
    task automatic run_random_mix(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                send_force(random_thrust());
            end
            else if (r < 70)
            begin
                send_voltage(random_voltage());
            end
            else if (r < 85)
            begin
                send_write(2'($urandom_range(0, 2)), 8'($urandom_range(0, TABLE_ENTRIES - 1)),
                           16'($urandom));
            end
            else if (r < 93)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_write(SEL_BAD, 8'($urandom), 16'($urandom));
                end
                else
                begin
                    send_write(2'($urandom_range(0, 2)),
                               8'($urandom_range(TABLE_ENTRIES, 255)), 16'($urandom));
                end
            end
            else
            begin
                send_item(random_beat(FUNC_UNUSED));
            end
        end
    endtask

    // Stop offering beats and wait until every predicted beat has come out.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A force right after reset uses the reset voltage and an empty frame.
    task automatic test_reset_state();
        send_force(16'sd4096);
    endtask

    // Full-scale table words, clamped voltages and saturated forces.
    task automatic test_table_extremes();
        send_write(SEL_14V, 8'd0, 16'hFFFF);
        send_write(SEL_16V, 8'd0, 16'h0000);
        send_write(SEL_18V, 8'd0, 16'hFFFF);
        send_voltage(16'd0);
        send_force(-16'sd32768);
        send_voltage(16'd15001);
        send_force(-16'sd16384);
        send_voltage(16'hFFFF);
        send_force(-16'sd16384);
        send_voltage(16'(V_MID_MV));
        send_force(-16'sd20000);
        send_voltage(16'(V_MID_MV + 1));
        send_force(-16'sd16384);
        send_force(16'sd16384);
    endtask

    // Forces on both sides of exact half-index points, and the top index.
    task automatic test_index_rounding();
        send_voltage(16'(V_LOW_MV));
        send_force(16'sd2047);
        send_force(16'sd2048);
        send_force(-16'sd2048);
        send_force(-16'sd2049);
        send_force(16'sd32767);
    endtask

    // Beats the block must ignore without any effect.
    task automatic test_ignored_items();
        send_write(SEL_BAD, 8'd5, 16'h1234);
        send_write(SEL_14V, 8'(TABLE_ENTRIES), 16'hABCD);
        send_write(SEL_18V, 8'd255, 16'h5A5A);
        send_item(random_beat(FUNC_UNUSED));
    endtask

    task automatic test_random_traffic();
        sender_idle_en = 1'b1;
        recv_idle_en   = 1'b1;
        run_random_mix(100);
    endtask

    // The receiver holds off long enough for the queue to fill and the
    // input to stall while the sender keeps offering forces.
    task automatic test_output_backpressure();
        sender_idle_en = 1'b0;
        hold_left = LONG_HOLD;
        repeat (16) send_force(random_thrust());
        sender_idle_en = 1'b1;
    endtask

    // The sender goes quiet until the output has fully drained.
    task automatic test_sender_pause();
        repeat (2)
        begin
            run_random_mix(20);
            pause_until_drained();
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_steady_stream();
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
        run_random_mix(50);
    endtask

    // Receiver stall: long hold first, then random bursts.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (recv_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(1, 11) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted output beat with the oldest prediction.
    initial
    begin
        frame_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (frame_bytes_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat byte %02h pwm %04h last %0b",
                                              serial_byte, pwm_value, frame_last));
                end
                else
                begin
                    want = frame_bytes_q.pop_front();
                    n_checked++;
                    if (serial_byte !== want.sbyte)
                    begin
                        report_mismatch($sformatf("serial_byte got %02h want %02h",
                                                  serial_byte, want.sbyte));
                    end
                    if (pwm_value !== want.pwm)
                    begin
                        report_mismatch($sformatf("pwm_value got %04h want %04h",
                                                  pwm_value, want.pwm));
                    end
                    if (frame_last !== want.last)
                    begin
                        report_mismatch($sformatf("frame_last got %0b want %0b",
                                                  frame_last, want.last));
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Watchdog expired with %0d beats still expected.", frame_bytes_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_table_extremes();
        test_index_rounding();
        test_ignored_items();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();

        pause_until_drained();
        repeat (30) @(posedge clk);

        $display("Run covered %0d forces in %0d frames, %0d table writes, %0d voltage updates.",
                 n_forces, n_frames, n_writes, n_volts);
        $display("It checked %0d output beats; %0d ignored beats; %0d mismatches.",
                 n_checked, n_ignored, errors);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* thrust_to_pwm_interpolating_framer.f */
design/tpf_pkg.sv
design/tpf_ram.sv
design/tpf_front.sv
design/tpf_queue.sv
design/tpf_back.sv
design/tpf_framer.sv
design/thrust_to_pwm_interpolating_framer.sv
tb/thrust_to_pwm_interpolating_framer_tb.sv
